[rtl/skpc_pkg.sv]
// ---------------------------------------------------------------------------
// skpc_pkg: shared constants and tables for the soft-knee peak compressor
// Fixed-point widths, dB constants, register indexes and the square-root
// chain used by the exponent stage.
// ---------------------------------------------------------------------------
package skpc_pkg;

    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int DB_TABLE_BITS_DEF = 10;
    localparam int MAX_TABLE_BITS    = 14;

    // shared multiplier: signed operands, full product
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // serial divider: dividend and divisor widths
    localparam int DIV_N_W = 42;
    localparam int DIV_D_W = 22;

    localparam int ENV_W = 24;

    // -96 dB and -128 dB in signed Q8.16
    localparam logic signed [ENV_W-1:0] FLOOR_DB_Q16 = 24'hA00000;
    localparam logic signed [ENV_W-1:0] MIN_DB_Q16   = 24'h800000;

    localparam logic [18:0] DB_PER_LOG2_Q16 = 19'd394566;
    localparam logic [13:0] LOG2_PER_DB_Q16 = 14'd10885;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_RATIO     = 3'd1,
        REG_KNEE      = 3'd2,
        REG_MAKEUP    = 3'd3,
        REG_ATTACK    = 3'd4,
        REG_RELEASE   = 3'd5,
        REG_BYPASS    = 3'd6,
        REG_STEREO    = 3'd7
    } cfg_idx_t;

    typedef logic [MAX_TABLE_BITS:0][31:0] root_tbl_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // root[0] = 2.0 in Q2.30, root[k] = sqrt(root[k-1]) in Q2.30
    function automatic root_tbl_t root_table();
        root_tbl_t   t;
        logic [63:0] prev;
        t    = '0;
        prev = 64'd1 << 31;
        t[0] = 32'h8000_0000;
        for (int k = 1; k <= MAX_TABLE_BITS; k++) begin
            prev = isqrt64(prev << 30);
            t[k] = prev[31:0];
        end
        return t;
    endfunction

endpackage

[rtl/skpc_mul.sv]
// ---------------------------------------------------------------------------
// skpc_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ---------------------------------------------------------------------------
module skpc_mul (
    input  logic                                     aclk,
    input  logic signed [skpc_pkg::MUL_W-1:0]        mul_a,
    input  logic signed [skpc_pkg::MUL_W-1:0]        mul_b,
    output logic signed [skpc_pkg::PROD_W-1:0]       prod
);

    logic signed [skpc_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

[rtl/skpc_div.sv]
// ---------------------------------------------------------------------------
// skpc_div: serial restoring divider
// Unsigned quotient, one bit per cycle; done holds until the next start.
// ---------------------------------------------------------------------------
module skpc_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [skpc_pkg::DIV_N_W-1:0]        dividend,
    input  logic [skpc_pkg::DIV_D_W-1:0]        divisor,
    output logic                                done,
    output logic [skpc_pkg::DIV_N_W-1:0]        quotient
);

    localparam int NW = skpc_pkg::DIV_N_W;
    localparam int DW = skpc_pkg::DIV_D_W;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] quo_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[NW-1]};
        ge       = trial >= {1'b0, dvs_reg};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_next = {quo_reg[NW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(NW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/soft_knee_peak_compressor_top.sv]
// ---------------------------------------------------------------------------
// soft_knee_peak_compressor_top: soft-knee peak compressor, one frame a beat
// Sequencer around one shared multiplier and one serial divider.
// ---------------------------------------------------------------------------
// Each input beat is a stereo frame. The block takes the louder sample (the
// left one in mono mode), measures its level in dB (leading-zero count plus
// DB_TABLE_BITS squaring steps), runs a one-pole dB envelope, computes the
// soft-knee gain, adds makeup and turns the total into a linear gain by a
// chain of square-root factors. A frame goes through these steps in order:
// taking the beat, normalizing the peak one leading zero at a time (skipped
// for a silent frame), the squarings on the shared multiplier, the dB scale,
// the envelope, starting the slope division and waiting on the serial
// divider, a second division inside the soft knee, folding in any
// reduction, the log2 gain, one multiply per set exponent bit, two output
// multiplies and loading the output register. Bypass frames go straight
// from taking the beat to the output register. s_ready is high only while
// the sequencer is idle; a finished frame waits in the output register so
// the next frame can be taken while the result is still pending.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// ---------------------------------------------------------------------------
module soft_knee_peak_compressor_top #(
    parameter int SAMPLE_BITS   = skpc_pkg::SAMPLE_BITS_DEF,
    parameter int DB_TABLE_BITS = skpc_pkg::DB_TABLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_addr,
    input  logic [15:0]                   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_left_in,
    input  logic signed [SAMPLE_BITS-1:0] s_right_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out
);

    localparam int SB     = SAMPLE_BITS;
    localparam int F      = DB_TABLE_BITS;
    localparam int ZW     = $clog2(SB);
    localparam int MUL_W  = skpc_pkg::MUL_W;
    localparam int PROD_W = skpc_pkg::PROD_W;
    localparam int ENV_W  = skpc_pkg::ENV_W;
    localparam int OVER_W = 26;
    localparam int GDB_W  = 28;
    localparam int SH_MAX = PROD_W - 1;
    localparam int SH_W   = $clog2(PROD_W);

    localparam skpc_pkg::root_tbl_t ROOTS = skpc_pkg::root_table();

    localparam logic signed [PROD_W-1:0] SAT_HI =
        (PROD_W'(1) << (SB - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

    typedef enum logic [20:0] {
        ST_IDLE     = 21'd1 << 0,
        ST_LZ       = 21'd1 << 1,
        ST_SQ_ISSUE = 21'd1 << 2,
        ST_SQ_TAKE  = 21'd1 << 3,
        ST_L2_ISSUE = 21'd1 << 4,
        ST_L2_TAKE  = 21'd1 << 5,
        ST_ENV_A    = 21'd1 << 6,
        ST_ENV_B    = 21'd1 << 7,
        ST_ENV_C    = 21'd1 << 8,
        ST_GC       = 21'd1 << 9,
        ST_DIV_M    = 21'd1 << 10,
        ST_X_TAKE   = 21'd1 << 11,
        ST_DIV_Q    = 21'd1 << 12,
        ST_RED_TAKE = 21'd1 << 13,
        ST_G_ISSUE  = 21'd1 << 14,
        ST_G_TAKE   = 21'd1 << 15,
        ST_EXP      = 21'd1 << 16,
        ST_EXP_TAKE = 21'd1 << 17,
        ST_OUTL     = 21'd1 << 18,
        ST_OUTR     = 21'd1 << 19,
        ST_DONE     = 21'd1 << 20
    } state_t;

    // configuration
    logic signed [15:0] thr_reg;
    logic [14:0]        ratio_reg;
    logic [12:0]        knee_reg;
    logic signed [13:0] makeup_reg;
    logic [15:0]        attack_reg;
    logic [15:0]        release_reg;
    logic               bypass_reg;
    logic               stereo_reg;

    // control and state
    state_t                  state_reg, state_next;
    logic signed [ENV_W-1:0] env_reg, env_next;
    logic                    m_valid_reg, m_valid_next;

    // datapath
    logic signed [SB-1:0]     l_reg, l_next;
    logic signed [SB-1:0]     r_reg, r_next;
    logic [SB-1:0]            norm_reg, norm_next;
    logic [ZW-1:0]            z_reg, z_next;
    logic [30:0]              mant_reg, mant_next;
    logic [F-1:0]             frac_reg, frac_next;
    logic [3:0]               k_reg, k_next;
    logic signed [ENV_W-1:0]  lev_reg, lev_next;
    logic [15:0]              coef_reg, coef_next;
    logic signed [43:0]       acc_reg, acc_next;
    logic signed [OVER_W-1:0] over_reg, over_next;
    logic [15:0]              slope_reg, slope_next;
    logic signed [GDB_W-1:0]  gdb_reg, gdb_next;
    logic signed [11:0]       n_reg, n_next;
    logic [15:0]              f_reg, f_next;
    logic [31:0]              g_reg, g_next;
    logic signed [SB-1:0]     res_l_reg, res_l_next;
    logic signed [SB-1:0]     res_r_reg, res_r_next;
    logic signed [SB-1:0]     out_l_reg, out_l_next;
    logic signed [SB-1:0]     out_r_reg, out_r_next;

    // shared units
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start;
    logic [skpc_pkg::DIV_N_W-1:0] div_dividend;
    logic [skpc_pkg::DIV_D_W-1:0] div_divisor;
    logic                     div_done;
    logic [skpc_pkg::DIV_N_W-1:0] div_quot;

    skpc_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    skpc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // helper values
    logic [SB-1:0]            abs_l, abs_r, peak;
    logic [31:0]              sq;
    logic signed [PROD_W-1:0] db_full;
    logic signed [43:0]       env_sum;
    logic [14:0]              rat;
    logic signed [OVER_W-1:0] half_s;
    logic signed [OVER_W-1:0] x_val;
    logic                     soft_hit;
    logic signed [12:0]       sh_full;
    logic [SH_W-1:0]          sh;
    logic signed [PROD_W-1:0] shifted;
    logic signed [SB-1:0]     sat_val;
    logic signed [MUL_W-1:0]  l2;
    logic [SB+30:0]           norm_wide;

    always_comb begin
        abs_l   = s_left_in[SB-1] ? SB'(-s_left_in) : SB'(s_left_in);
        abs_r   = s_right_in[SB-1] ? SB'(-s_right_in) : SB'(s_right_in);
        peak    = (stereo_reg && (abs_r > abs_l)) ? abs_r : abs_l;
        norm_wide = {norm_reg, 31'b0} >> SB;
        sq      = prod[61:30];
        l2      = MUL_W'(frac_reg) - (MUL_W'(z_reg) << F);
        db_full = prod >>> F;
        env_sum = acc_reg + $signed(prod[43:0]);
        rat     = (ratio_reg < 15'd256) ? 15'd256 : ratio_reg;
        half_s  = $signed(OVER_W'({knee_reg, 7'b0}));
        x_val   = over_reg + half_s;
        soft_hit = (knee_reg != 13'd0) && (over_reg > -half_s) && (over_reg < half_s);
        // output scaling: floor(prod / 2^(30-n)), then clamp to sample range
        sh_full = 13'sd30 - 13'(n_reg);
        sh      = (sh_full > 13'(SH_MAX)) ? SH_W'(SH_MAX) : sh_full[SH_W-1:0];
        shifted = prod >>> sh;
        if (shifted > SAT_HI) begin
            sat_val = SAT_HI[SB-1:0];
        end else if (shifted < SAT_LO) begin
            sat_val = SAT_LO[SB-1:0];
        end else begin
            sat_val = shifted[SB-1:0];
        end
    end

    // handshake
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_left_out  = out_l_reg;
    assign m_right_out = out_r_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        env_next     = env_reg;
        m_valid_next = m_valid_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        norm_next    = norm_reg;
        z_next       = z_reg;
        mant_next    = mant_reg;
        frac_next    = frac_reg;
        k_next       = k_reg;
        lev_next     = lev_reg;
        coef_next    = coef_reg;
        acc_next     = acc_reg;
        over_next    = over_reg;
        slope_next   = slope_reg;
        gdb_next     = gdb_reg;
        n_next       = n_reg;
        f_next       = f_reg;
        g_next       = g_reg;
        res_l_next   = res_l_reg;
        res_r_next   = res_r_reg;
        out_l_next   = out_l_reg;
        out_r_next   = out_r_reg;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;

        // drop the output beat once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    l_next = s_left_in;
                    r_next = s_right_in;
                    if (bypass_reg) begin
                        // pass through, hold the envelope
                        res_l_next = s_left_in;
                        res_r_next = stereo_reg ? s_right_in : '0;
                        state_next = ST_DONE;
                    end else if (peak == '0) begin
                        lev_next   = skpc_pkg::FLOOR_DB_Q16;
                        state_next = ST_ENV_A;
                    end else begin
                        norm_next  = peak;
                        z_next     = '0;
                        state_next = ST_LZ;
                    end
                end
            end
            ST_LZ: begin
                // normalize one bit a cycle
                if (norm_reg[SB-1]) begin
                    mant_next  = norm_wide[30:0];
                    frac_next  = '0;
                    k_next     = '0;
                    state_next = ST_SQ_ISSUE;
                end else begin
                    norm_next = {norm_reg[SB-2:0], 1'b0};
                    z_next    = z_reg + ZW'(1);
                end
            end
            ST_SQ_ISSUE: begin
                mul_a      = MUL_W'(mant_reg);
                mul_b      = MUL_W'(mant_reg);
                state_next = ST_SQ_TAKE;
            end
            ST_SQ_TAKE: begin
                // one log2 fraction bit per squaring
                if (sq[31]) begin
                    mant_next = sq[31:1];
                    frac_next = {frac_reg[F-2:0], 1'b1};
                end else begin
                    mant_next = sq[30:0];
                    frac_next = {frac_reg[F-2:0], 1'b0};
                end
                k_next = k_reg + 4'd1;
                state_next = (k_reg == 4'(F - 1)) ? ST_L2_ISSUE : ST_SQ_ISSUE;
            end
            ST_L2_ISSUE: begin
                mul_a      = l2;
                mul_b      = MUL_W'(skpc_pkg::DB_PER_LOG2_Q16);
                state_next = ST_L2_TAKE;
            end
            ST_L2_TAKE: begin
                if (db_full < PROD_W'(skpc_pkg::MIN_DB_Q16)) begin
                    lev_next = skpc_pkg::MIN_DB_Q16;
                end else begin
                    lev_next = db_full[ENV_W-1:0];
                end
                state_next = ST_ENV_A;
            end
            ST_ENV_A: begin
                coef_next  = (lev_reg > env_reg) ? attack_reg : release_reg;
                mul_a      = MUL_W'((lev_reg > env_reg) ? attack_reg : release_reg);
                mul_b      = MUL_W'(env_reg);
                state_next = ST_ENV_B;
            end
            ST_ENV_B: begin
                acc_next   = $signed(prod[43:0]);
                mul_a      = MUL_W'(17'h10000 - {1'b0, coef_reg});
                mul_b      = MUL_W'(lev_reg);
                state_next = ST_ENV_C;
            end
            ST_ENV_C: begin
                env_next   = env_sum[39:16];
                state_next = ST_GC;
            end
            ST_GC: begin
                over_next    = OVER_W'(env_reg) - (OVER_W'(thr_reg) <<< 8);
                div_start    = 1'b1;
                div_dividend = skpc_pkg::DIV_N_W'(rat - 15'd256) << 16;
                div_divisor  = skpc_pkg::DIV_D_W'(rat);
                state_next   = ST_DIV_M;
            end
            ST_DIV_M: begin
                if (div_done) begin
                    slope_next = div_quot[15:0];
                    if (soft_hit) begin
                        mul_a      = MUL_W'(x_val);
                        mul_b      = MUL_W'(x_val);
                        state_next = ST_X_TAKE;
                    end else if (over_reg >= half_s) begin
                        mul_a      = MUL_W'(over_reg);
                        mul_b      = MUL_W'(div_quot[15:0]);
                        state_next = ST_RED_TAKE;
                    end else begin
                        gdb_next   = GDB_W'(makeup_reg) <<< 8;
                        state_next = ST_G_ISSUE;
                    end
                end
            end
            ST_X_TAKE: begin
                div_start    = 1'b1;
                div_dividend = prod[skpc_pkg::DIV_N_W-1:0];
                div_divisor  = {knee_reg, 9'b0};
                state_next   = ST_DIV_Q;
            end
            ST_DIV_Q: begin
                if (div_done) begin
                    mul_a      = MUL_W'(div_quot[20:0]);
                    mul_b      = MUL_W'(slope_reg);
                    state_next = ST_RED_TAKE;
                end
            end
            ST_RED_TAKE: begin
                gdb_next   = (GDB_W'(makeup_reg) <<< 8) - $signed(prod[GDB_W+15:16]);
                state_next = ST_G_ISSUE;
            end
            ST_G_ISSUE: begin
                mul_a      = MUL_W'(gdb_reg);
                mul_b      = MUL_W'(skpc_pkg::LOG2_PER_DB_Q16);
                state_next = ST_G_TAKE;
            end
            ST_G_TAKE: begin
                // integer and fraction parts of log2 gain
                n_next     = prod[43:32];
                f_next     = prod[31:16];
                g_next     = 32'h4000_0000;
                k_next     = 4'd1;
                state_next = ST_EXP;
            end
            ST_EXP: begin
                if (k_reg > 4'(F)) begin
                    mul_a      = MUL_W'(l_reg);
                    mul_b      = MUL_W'(g_reg);
                    state_next = ST_OUTL;
                end else if (f_reg[4'(5'd16 - 5'(k_reg))]) begin
                    mul_a      = MUL_W'(g_reg);
                    mul_b      = MUL_W'(ROOTS[k_reg]);
                    state_next = ST_EXP_TAKE;
                end else begin
                    k_next = k_reg + 4'd1;
                end
            end
            ST_EXP_TAKE: begin
                g_next     = prod[61:30];
                k_next     = k_reg + 4'd1;
                state_next = ST_EXP;
            end
            ST_OUTL: begin
                res_l_next = sat_val;
                mul_a      = MUL_W'(r_reg);
                mul_b      = MUL_W'(g_reg);
                state_next = ST_OUTR;
            end
            ST_OUTR: begin
                res_r_next = stereo_reg ? sat_val : '0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_l_next   = res_l_reg;
                    out_r_next   = res_r_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            env_reg     <= skpc_pkg::FLOOR_DB_Q16;
            thr_reg     <= 16'hEC00;
            ratio_reg   <= 15'd1024;
            knee_reg    <= 13'd1536;
            makeup_reg  <= '0;
            attack_reg  <= 16'd64880;
            release_reg <= 16'd65500;
            bypass_reg  <= 1'b0;
            stereo_reg  <= 1'b1;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            env_reg     <= env_next;
            if (cfg_we) begin
                case (skpc_pkg::cfg_idx_t'(cfg_addr))
                    skpc_pkg::REG_THRESHOLD: thr_reg     <= cfg_wdata;
                    skpc_pkg::REG_RATIO:     ratio_reg   <= cfg_wdata[14:0];
                    skpc_pkg::REG_KNEE:      knee_reg    <= cfg_wdata[12:0];
                    skpc_pkg::REG_MAKEUP:    makeup_reg  <= cfg_wdata[13:0];
                    skpc_pkg::REG_ATTACK:    attack_reg  <= cfg_wdata;
                    skpc_pkg::REG_RELEASE:   release_reg <= cfg_wdata;
                    skpc_pkg::REG_BYPASS:    bypass_reg  <= cfg_wdata[0];
                    skpc_pkg::REG_STEREO:    stereo_reg  <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        l_reg     <= l_next;
        r_reg     <= r_next;
        norm_reg  <= norm_next;
        z_reg     <= z_next;
        mant_reg  <= mant_next;
        frac_reg  <= frac_next;
        k_reg     <= k_next;
        lev_reg   <= lev_next;
        coef_reg  <= coef_next;
        acc_reg   <= acc_next;
        over_reg  <= over_next;
        slope_reg <= slope_next;
        gdb_reg   <= gdb_next;
        n_reg     <= n_next;
        f_reg     <= f_next;
        g_reg     <= g_next;
        res_l_reg <= res_l_next;
        res_r_reg <= res_r_next;
        out_l_reg <= out_l_next;
        out_r_reg <= out_r_next;
    end

endmodule

[bench/skpc_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// skpc_checker: frame predictor and result comparator for the compressor
// Watches the frame and result channels and the configuration port, keeps its
// own envelope and register copies, and compares each result beat in order.
// ---------------------------------------------------------------------------
module skpc_checker #(
    parameter int SB = 24,
    parameter int TB = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_addr,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic signed [SB-1:0] s_left_in,
    input  logic signed [SB-1:0] s_right_in,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic signed [SB-1:0] m_left_out,
    input  logic signed [SB-1:0] m_right_out,
    output int                   fail_count,
    output int                   pending_frames
);
    typedef struct packed {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
    } frame_t;

    logic [15:0] thr_r, atk_r, rel_r;
    logic [14:0] ratio_r;
    logic [12:0] knee_r;
    logic [13:0] makeup_r;
    logic        byp_r, stereo_r;
    longint      env_db;
    longint      root_q30 [TB+1];
    frame_t      expected_frames [$];

    function automatic longint floor_shr(longint v, int s);
        if (s > 62) return (v < 0) ? -1 : 0;
        return v >>> s;
    endfunction

    function automatic longint sqrt_u(longint v);
        longint r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint level_of(longint p);
        int     e;
        longint m, frac, l2, db;
        if (p == 0) return -6291456;
        e = 0;
        while ((p >> (e + 1)) != 0) e++;
        m = (e <= 30) ? (p << (30 - e)) : (p >> (e - 30));
        frac = 0;
        for (int k = 0; k < TB; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        l2 = (e - (SB - 1)) * (64'sd1 << TB) + frac;
        db = floor_shr(l2 * 394566, TB);
        return db < -8388608 ? -8388608 : db;
    endfunction

    function automatic logic [SB-1:0] scaled(longint s, longint g, longint n);
        longint v, hi, lo;
        hi = (64'sd1 <<< (SB - 1)) - 1;
        lo = -hi - 1;
        v = floor_shr(s * g, 30 - n);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[SB-1:0];
    endfunction

    // advance the envelope (held in bypass) and return the expected output frame
    function automatic frame_t compress_frame(longint l, longint r);
        frame_t o;
        longint pl, pr, pk, lev, a, rat, m, over, half, gdb, x, q, y, n, f, g;
        if (byp_r) begin
            o.left  = l[SB-1:0];
            o.right = stereo_r ? r[SB-1:0] : '0;
            return o;
        end
        pl = l < 0 ? -l : l;
        pr = r < 0 ? -r : r;
        pk = (stereo_r && pr > pl) ? pr : pl;
        lev = level_of(pk);
        a = (lev > env_db) ? longint'(atk_r) : longint'(rel_r);
        env_db = floor_shr(a * env_db + (65536 - a) * lev, 16);
        rat = ratio_r < 256 ? 256 : longint'(ratio_r);
        m = ((rat - 256) << 16) / rat;
        over = env_db - longint'($signed(thr_r)) * 256;
        half = longint'(knee_r) * 128;
        gdb = 0;
        if (knee_r > 0 && over > -half && over < half) begin
            x = over + half;
            q = (x * x) / (2 * longint'(knee_r) * 256);
            gdb = -((q * m) >> 16);
        end else if (over >= half) begin
            gdb = -((over * m) >> 16);
        end
        gdb = gdb + longint'($signed(makeup_r)) * 256;
        y = floor_shr(gdb * 10885, 16);
        n = floor_shr(y, 16);
        f = y - n * 65536;
        g = 64'd1 << 30;
        for (int k = 1; k <= TB; k++)
            if ((f >> (16 - k)) & 1) g = (g * root_q30[k]) >> 30;
        o.left  = scaled(l, g, n);
        o.right = stereo_r ? scaled(r, g, n) : '0;
        return o;
    endfunction

    initial begin
        root_q30[0] = 64'd2 << 30;
        for (int k = 1; k <= TB; k++) root_q30[k] = sqrt_u(root_q30[k-1] << 30);
    end

    initial pending_frames = 0;

    always @(posedge aclk) begin
        frame_t want;
        if (!aresetn) begin
            thr_r <= 16'hEC00; ratio_r <= 15'd1024; knee_r <= 13'd1536;
            makeup_r <= '0; atk_r <= 16'd64880; rel_r <= 16'd65500;
            byp_r <= 1'b0; stereo_r <= 1'b1;
            env_db = -6291456;
            fail_count <= 0;
            expected_frames.delete();
        end else begin
            if (cfg_we) begin
                case (skpc_pkg::cfg_idx_t'(cfg_addr))
                    skpc_pkg::REG_THRESHOLD: thr_r    <= cfg_wdata;
                    skpc_pkg::REG_RATIO:     ratio_r  <= cfg_wdata[14:0];
                    skpc_pkg::REG_KNEE:      knee_r   <= cfg_wdata[12:0];
                    skpc_pkg::REG_MAKEUP:    makeup_r <= cfg_wdata[13:0];
                    skpc_pkg::REG_ATTACK:    atk_r    <= cfg_wdata;
                    skpc_pkg::REG_RELEASE:   rel_r    <= cfg_wdata;
                    skpc_pkg::REG_BYPASS:    byp_r    <= cfg_wdata[0];
                    skpc_pkg::REG_STEREO:    stereo_r <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_frames.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat L=%0d R=%0d", m_left_out, m_right_out);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_frames.pop_front();
                    if (want.left !== m_left_out || want.right !== m_right_out) begin
                        if (fail_count < 10)
                            $display("mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                                     want.left, want.right, m_left_out, m_right_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_frames.push_back(compress_frame(s_left_in, s_right_in));
        end
        pending_frames = expected_frames.size();
    end
endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: soft-knee peak compressor testbench
// Directed and random stereo frames over several register settings and
// idle/stall phases; results are checked by skpc_checker.
// ---------------------------------------------------------------------------
module tb;
    localparam int SB = 24;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [2:0]           cfg_addr = '0;
    logic [15:0]          cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic signed [SB-1:0] s_left_in = '0;
    logic signed [SB-1:0] s_right_in = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [SB-1:0] m_left_out;
    logic signed [SB-1:0] m_right_out;
    int                   fail_count;
    int                   pending_frames;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    soft_knee_peak_compressor_top u_dut (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_valid, .s_ready, .s_left_in, .s_right_in,
        .m_valid, .m_ready, .m_left_out, .m_right_out
    );

    skpc_checker #(.SB(SB), .TB(10)) u_checker (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_valid, .s_ready, .s_left_in, .s_right_in,
        .m_valid, .m_ready, .m_left_out, .m_right_out,
        .fail_count, .pending_frames
    );

    // receiver: redraw ready at each falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // drop valid, then write one register
    task automatic write_reg(input skpc_pkg::cfg_idx_t idx, input logic [15:0] val);
        s_valid   <= 1'b0;
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // present one beat; hold it until the block takes it
    task automatic send_frame(input logic [SB-1:0] l, input logic [SB-1:0] r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_left_in  <= l;
        s_right_in <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // drain all results, then let the sequencer settle before config writes
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_frames != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    function automatic logic [SB-1:0] rand_sample();
        case ($urandom_range(5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return SB'($urandom_range(3) - 2);
            3: return SB'($urandom >> $urandom_range(23, 8));
            4: return SB'(-($urandom >> $urandom_range(23, 8)));
            default: return SB'($urandom);
        endcase
    endfunction

    task automatic random_setting();
        write_reg(skpc_pkg::REG_THRESHOLD, 16'(-$urandom_range(24576)));
        write_reg(skpc_pkg::REG_RATIO, ($urandom_range(4) == 0) ?
                  16'($urandom_range(255)) : 16'($urandom_range(25600, 256)));
        write_reg(skpc_pkg::REG_KNEE, ($urandom_range(3) == 0) ?
                  16'd0 : 16'($urandom_range(6144)));
        write_reg(skpc_pkg::REG_MAKEUP, 16'($urandom_range(12288) - 6144));
        write_reg(skpc_pkg::REG_ATTACK, ($urandom_range(3) == 0) ?
                  16'($urandom) : 16'($urandom_range(65535, 60000)));
        write_reg(skpc_pkg::REG_RELEASE, ($urandom_range(3) == 0) ?
                  16'($urandom) : 16'($urandom_range(65535, 60000)));
        write_reg(skpc_pkg::REG_BYPASS, 16'($urandom_range(7) == 0));
        write_reg(skpc_pkg::REG_STEREO, 16'($urandom_range(3) != 0));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, silence, mono, bypass
        send_frame(24'h0, 24'h0);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h800000, 24'h7FFFFF);
        send_frame(24'h1, 24'hFFFFFF);
        send_frame(24'h7FFFFF, 24'h7FFFFF);
        send_frame(24'h000100, 24'h0);
        drain();
        write_reg(skpc_pkg::REG_THRESHOLD, 16'h0000);
        write_reg(skpc_pkg::REG_RATIO, 16'd25600);
        write_reg(skpc_pkg::REG_KNEE, 16'd0);
        write_reg(skpc_pkg::REG_MAKEUP, 16'd6144);
        write_reg(skpc_pkg::REG_ATTACK, 16'd0);
        write_reg(skpc_pkg::REG_RELEASE, 16'd0);
        send_frame(24'h7FFFFF, 24'h0);
        send_frame(24'h400000, 24'hC00000);
        send_frame(24'h0, 24'h7FFFFF);
        send_frame(24'h000010, 24'h800000);
        drain();
        write_reg(skpc_pkg::REG_THRESHOLD, -16'sd24576);
        write_reg(skpc_pkg::REG_RATIO, 16'd100);
        write_reg(skpc_pkg::REG_KNEE, 16'd6144);
        write_reg(skpc_pkg::REG_MAKEUP, -16'sd6144);
        write_reg(skpc_pkg::REG_ATTACK, 16'hFFFF);
        write_reg(skpc_pkg::REG_RELEASE, 16'hFFFF);
        write_reg(skpc_pkg::REG_STEREO, 16'd0);
        send_frame(24'h123456, 24'h7FFFFF);
        send_frame(24'h800000, 24'h7FFFFF);
        drain();
        write_reg(skpc_pkg::REG_BYPASS, 16'd1);
        send_frame(24'h800000, 24'h7FFFFF);
        drain();
        write_reg(skpc_pkg::REG_STEREO, 16'd1);
        send_frame(24'h7FFFFF, 24'h800000);
        send_frame(24'h000001, 24'hABCDEF);
        drain();

        // random phases: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 12; ph++) begin
            drain();
            random_setting();
            send_idle_pct  = (ph % 4 == 1) ? 54 : (ph % 4 == 3) ? 27 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 54 : (ph % 4 == 3) ? 27 : 0;
            for (int i = 0; i < 125; i++) send_frame(rand_sample(), rand_sample());
        end

        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule

[sim.f]
rtl/skpc_pkg.sv
rtl/skpc_mul.sv
rtl/skpc_div.sv
rtl/soft_knee_peak_compressor_top.sv
bench/skpc_checker.sv
bench/tb.sv
